// File: rtl/bste_pkg.sv
// ----------------------------------------------------------------------------
// bste_pkg
// Shared widths, operation and status codes and the result record of the
// binary search tree engine.
// ----------------------------------------------------------------------------
package bste_pkg;

    // default pool size, in nodes
    localparam int POOL_NODES_DEF = 1024;

    // fixed field widths
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;
    localparam int PROBE_W  = 11;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // one result record
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [PAY_W-1:0] found_payload;
        logic [INDEX_W-1:0]      node_index;
        logic [PROBE_W-1:0]      probe_count;
    } res_t;

endpackage

// File: rtl/bste_ram.sv
// ----------------------------------------------------------------------------
// bste_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module bste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/bste_walk.sv
// ----------------------------------------------------------------------------
// bste_walk
// Tree walker: takes one request, walks the node pool one node per cycle
// and produces one result record. Also places new nodes and links them.
// ----------------------------------------------------------------------------
module bste_walk #(
    parameter int POOL_NODES = bste_pkg::POOL_NODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request side
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic signed [bste_pkg::KEY_W-1:0]   key,
    input  logic signed [bste_pkg::PAY_W-1:0]   payload,
    // result side
    output logic                                res_valid,
    input  logic                                res_take,
    output bste_pkg::res_t                      res
);

    localparam int IDX_W  = $clog2(POOL_NODES);
    localparam int CNT_W  = $clog2(POOL_NODES + 1);
    localparam int LINK_W = IDX_W + 1;
    localparam int WORD_W = bste_pkg::KEY_W + bste_pkg::PAY_W + 2 * LINK_W;

    // node word layout: {key, payload, left, right}
    localparam int R_LO = 0;
    localparam int L_LO = LINK_W;
    localparam int P_LO = 2 * LINK_W;
    localparam int K_LO = P_LO + bste_pkg::PAY_W;

    localparam logic [LINK_W-1:0] LINK_NONE = '1;
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(POOL_NODES);

    // walker states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] probes_reg, probes_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    bste_pkg::res_t   res_reg, res_next;

    logic                              op_reg;
    logic signed [bste_pkg::KEY_W-1:0] key_reg;
    logic [IDX_W-1:0]                  slot_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic signed [bste_pkg::KEY_W-1:0] node_key;
    logic signed [bste_pkg::PAY_W-1:0] node_pay;
    logic [LINK_W-1:0]                 node_left;
    logic [LINK_W-1:0]                 node_right;
    logic [LINK_W-1:0]                 next_link;
    logic [LINK_W-1:0]                 slot_link;
    logic                              key_gt;
    logic                              key_eq;
    logic                              accept;

    // node pool
    bste_ram #(
        .WIDTH (WORD_W),
        .DEPTH (POOL_NODES)
    ) u_pool (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // fields of the node just read
    assign node_key   = $signed(rd_data[K_LO +: bste_pkg::KEY_W]);
    assign node_pay   = $signed(rd_data[P_LO +: bste_pkg::PAY_W]);
    assign node_left  = rd_data[L_LO +: LINK_W];
    assign node_right = rd_data[R_LO +: LINK_W];

    // signed compare; equal keys go left
    assign key_gt    = key_reg > node_key;
    assign key_eq    = key_reg == node_key;
    assign next_link = key_gt ? node_right : node_left;
    assign slot_link = {1'b0, slot_reg};

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // walker control
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        probes_next = probes_reg;
        cur_next    = cur_reg;
        res_next    = res_reg;
        wr_en       = 1'b0;
        wr_addr     = cur_reg;
        wr_data     = rd_data;
        rd_addr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next                = '0;
                    probes_next             = '0;
                    res_next.found_payload  = '0;
                    res_next.node_index     = '0;
                    res_next.probe_count    = '0;
                    if (opcode == bste_pkg::OP_INSERT)
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            res_next.status = bste_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // place the new node with both links empty
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDX_W-1:0];
                            wr_data    = {key, payload, LINK_NONE, LINK_NONE};
                            count_next = count_reg + CNT_W'(1);
                            if (count_reg == '0)
                            begin
                                res_next.status = bste_pkg::ST_INSERTED;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = bste_pkg::ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                probes_next = probes_reg + CNT_W'(1);
                if ((op_reg == bste_pkg::OP_SEARCH) && key_eq)
                begin
                    res_next.status        = bste_pkg::ST_FOUND;
                    res_next.found_payload = node_pay;
                    res_next.node_index    = bste_pkg::INDEX_W'(cur_reg);
                    res_next.probe_count   = bste_pkg::PROBE_W'(probes_next);
                    state_next             = S_DONE;
                end
                else if (next_link == LINK_NONE)
                begin
                    res_next.probe_count = bste_pkg::PROBE_W'(probes_next);
                    if (op_reg == bste_pkg::OP_INSERT)
                    begin
                        // hook the new node onto the empty child
                        wr_en   = 1'b1;
                        wr_addr = cur_reg;
                        if (key_gt)
                        begin
                            wr_data = {node_key, node_pay, node_left, slot_link};
                        end
                        else
                        begin
                            wr_data = {node_key, node_pay, slot_link, node_right};
                        end
                        res_next.status     = bste_pkg::ST_INSERTED;
                        res_next.node_index = bste_pkg::INDEX_W'(slot_reg);
                    end
                    else
                    begin
                        res_next.status = bste_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    // step down: fetch the child
                    cur_next = next_link[IDX_W-1:0];
                    rd_addr  = next_link[IDX_W-1:0];
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // request and walk registers
    always_ff @(posedge clk)
    begin
        probes_reg <= probes_next;
        cur_reg    <= cur_next;
        res_reg    <= res_next;
        if (accept)
        begin
            op_reg   <= opcode;
            key_reg  <= key;
            slot_reg <= count_reg[IDX_W-1:0];
        end
    end

endmodule

// File: rtl/binary_search_tree_engine_unit.sv
// ----------------------------------------------------------------------------
// binary_search_tree_engine_unit
// Unbalanced binary search tree over a node pool: insert and search.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall): opcode 0 inserts key with
//   payload, opcode 1 searches for key. A request is taken when in_valid is
//   high and in_stall low; in_stall is high from acceptance until the
//   result has moved into the output register.
//   Result channel (out_valid / out_stall): one result per request, held in
//   an output register until out_stall is low.
//   Timing: a request walks the tree one node per cycle, paced by the
//   registered read of the node pool RAM. The root insert, a full pool
//   or an empty tree go straight to the result without a walk; the next
//   request is taken only after the result has been loaded.
//   A stalled result blocks only once a second result is ready to load.
//   Reset empties the tree (node count zero); pool contents need no clearing.
// ----------------------------------------------------------------------------
module binary_search_tree_engine_unit #(
    parameter int POOL_NODES = bste_pkg::POOL_NODES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic signed [bste_pkg::KEY_W-1:0]     key,
    input  logic signed [bste_pkg::PAY_W-1:0]     payload,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [bste_pkg::STATUS_W-1:0]         status,
    output logic signed [bste_pkg::PAY_W-1:0]     found_payload,
    output logic [bste_pkg::INDEX_W-1:0]          node_index,
    output logic [bste_pkg::PROBE_W-1:0]          probe_count
);

    logic           res_valid;
    logic           res_take;
    bste_pkg::res_t res;

    logic           out_valid_reg, out_valid_next;
    bste_pkg::res_t out_res_reg;

    bste_walk #(
        .POOL_NODES (POOL_NODES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .key       (key),
        .payload   (payload),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register is free when empty or being drained
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign found_payload = out_res_reg.found_payload;
    assign node_index    = out_res_reg.node_index;
    assign probe_count   = out_res_reg.probe_count;

endmodule

// File: bench/tb_binary_search_tree_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_search_tree_engine_unit
// Self-checking bench for the tree engine. A short directed table opens the
// run. Random inserts and searches follow, with keys biased towards stored
// ones, their neighbours and the key extremes, until the pool fills up and
// further inserts are refused. Every result is checked field by field against
// a behavioural copy of the tree, while both sides idle at varying rates.
// ----------------------------------------------------------------------------
module tb_binary_search_tree_engine_unit;

    localparam int POOL           = bste_pkg::POOL_NODES_DEF;
    localparam int N_RANDOM       = 1035;
    localparam int SEG_LEN        = 150;
    localparam int FULL_MARGIN    = 10;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic signed [bste_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [bste_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // one row of the directed table
    typedef struct {
        logic                              op;
        logic signed [bste_pkg::KEY_W-1:0] key;
        logic signed [bste_pkg::PAY_W-1:0] pay;
        bit                                typed;
        bste_pkg::res_t                    want;
    } stim_row_t;

    // block ports
    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               in_valid      = 1'b0;
    logic                               in_stall;
    logic                               opcode        = bste_pkg::OP_INSERT;
    logic signed [bste_pkg::KEY_W-1:0]  key           = '0;
    logic signed [bste_pkg::PAY_W-1:0]  payload       = '0;
    logic                               out_valid;
    logic                               out_stall     = 1'b0;
    logic [bste_pkg::STATUS_W-1:0]      status;
    logic signed [bste_pkg::PAY_W-1:0]  found_payload;
    logic [bste_pkg::INDEX_W-1:0]       node_index;
    logic [bste_pkg::PROBE_W-1:0]       probe_count;

    // behavioural tree
    logic signed [bste_pkg::KEY_W-1:0] tree_key   [POOL];
    logic signed [bste_pkg::PAY_W-1:0] tree_pay   [POOL];
    int                                tree_left  [POOL];
    int                                tree_right [POOL];
    int                                tree_nodes = 0;

    bste_pkg::res_t pending_results [$];
    stim_row_t      directed_rows   [$];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int cnt_inserted   = 0;
    int cnt_found      = 0;
    int cnt_missed     = 0;
    int cnt_full       = 0;

    binary_search_tree_engine_unit #(
        .POOL_NODES (POOL)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .key           (key),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_payload (found_payload),
        .node_index    (node_index),
        .probe_count   (probe_count)
    );

    always #2 clk = ~clk;

    function automatic bste_pkg::res_t make_res(
        input logic [bste_pkg::STATUS_W-1:0]     st,
        input logic signed [bste_pkg::PAY_W-1:0] pay,
        input int                                idx,
        input int                                probes);
        bste_pkg::res_t r;
        r.status        = st;
        r.found_payload = pay;
        r.node_index    = bste_pkg::INDEX_W'(idx);
        r.probe_count   = bste_pkg::PROBE_W'(probes);
        return r;
    endfunction

    // Apply one request to the behavioural tree and return its result
    function automatic bste_pkg::res_t predict_tree_op(
        input logic                              op,
        input logic signed [bste_pkg::KEY_W-1:0] k,
        input logic signed [bste_pkg::PAY_W-1:0] p);
        int cur;
        int nxt;
        int probes;
        int slot;
        bit done;
        cur    = 0;
        probes = 0;
        done   = 1'b0;
        if (op == bste_pkg::OP_INSERT)
        begin
            // full pool: nothing stored
            if (tree_nodes >= POOL)
                return make_res(bste_pkg::ST_FULL, '0, 0, 0);
            slot             = tree_nodes;
            tree_key[slot]   = k;
            tree_pay[slot]   = p;
            tree_left[slot]  = -1;
            tree_right[slot] = -1;
            tree_nodes       = slot + 1;
            // walk from the root; equal keys go left
            if (slot != 0)
            begin
                while (!done)
                begin
                    probes++;
                    if (k > tree_key[cur])
                    begin
                        if (tree_right[cur] < 0)
                        begin
                            tree_right[cur] = slot;
                            done = 1'b1;
                        end
                        else
                            cur = tree_right[cur];
                    end
                    else
                    begin
                        if (tree_left[cur] < 0)
                        begin
                            tree_left[cur] = slot;
                            done = 1'b1;
                        end
                        else
                            cur = tree_left[cur];
                    end
                end
            end
            return make_res(bste_pkg::ST_INSERTED, '0, slot, probes);
        end
        // search: equality first, then branch
        if (tree_nodes == 0)
            return make_res(bste_pkg::ST_NOT_FOUND, '0, 0, 0);
        while (!done)
        begin
            probes++;
            if (k == tree_key[cur])
                return make_res(bste_pkg::ST_FOUND, tree_pay[cur], cur, probes);
            nxt = (k > tree_key[cur]) ? tree_right[cur] : tree_left[cur];
            if (nxt < 0)
                done = 1'b1;
            else
                cur = nxt;
        end
        return make_res(bste_pkg::ST_NOT_FOUND, '0, 0, probes);
    endfunction

    // Key mix: extremes, stored keys, their neighbours, otherwise anything
    function automatic logic signed [bste_pkg::KEY_W-1:0] pick_key(
        input bit for_search);
        int unsigned                       roll;
        int unsigned                       idx;
        logic signed [bste_pkg::KEY_W-1:0] k;
        roll = $urandom_range(99);
        k    = $urandom;
        idx  = (tree_nodes > 0) ? $urandom_range(tree_nodes - 1) : 0;
        if (roll < 3)
        begin
            case ($urandom_range(3))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = '0;
                default: k = -32'sd1;
            endcase
        end
        else if (tree_nodes > 0 && roll < (for_search ? 55 : 13))
            k = tree_key[idx];
        else if (tree_nodes > 0 && roll < (for_search ? 70 : 18))
            k = tree_key[idx] + (($urandom_range(1) == 1) ? 32'sd1 : -32'sd1);
        return k;
    endfunction

    task automatic add_row(input logic                              op,
                           input logic signed [bste_pkg::KEY_W-1:0] k,
                           input logic signed [bste_pkg::PAY_W-1:0] p,
                           input bit                                typed,
                           input bste_pkg::res_t                    want);
        stim_row_t row;
        row.op    = op;
        row.key   = k;
        row.pay   = p;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input int got,
                                   input int want);
        $display("MISMATCH %s: got %0d, expected %0d (at %0t)",
                 what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Present one request, hold it until taken, then queue its result.
    // in_valid is lowered only at the start of an idle gap, so back to back
    // requests never see two assignments in one step.
    task automatic send_request(input logic                              op,
                                input logic signed [bste_pkg::KEY_W-1:0] k,
                                input logic signed [bste_pkg::PAY_W-1:0] p,
                                input bste_pkg::res_t                    want);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        payload  <= p;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(want);
    endtask

    // Withdraw the request line and wait for every queued result
    task automatic drain_results();
        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result();
        bste_pkg::res_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with no request outstanding", int'(status), 0);
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
        if (found_payload !== want.found_payload)
            report_mismatch("found_payload", int'(found_payload),
                            int'(want.found_payload));
        if (node_index !== want.node_index)
            report_mismatch("node_index", int'(node_index), int'(want.node_index));
        if (probe_count !== want.probe_count)
            report_mismatch("probe_count", int'(probe_count), int'(want.probe_count));
        case (want.status)
            bste_pkg::ST_INSERTED:  cnt_inserted++;
            bste_pkg::ST_FOUND:     cnt_found++;
            bste_pkg::ST_NOT_FOUND: cnt_missed++;
            default:                cnt_full++;
        endcase
    endtask

    // Result side: check, then choose the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        bste_pkg::res_t                    want;
        logic                              op;
        logic signed [bste_pkg::KEY_W-1:0] k;
        logic signed [bste_pkg::PAY_W-1:0] p;
        int                                slots_left;
        int                                items_left;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table; expectations typed in where they are obvious
        add_row(bste_pkg::OP_SEARCH, '0, '0, 1'b1,
                make_res(bste_pkg::ST_NOT_FOUND, '0, 0, 0));
        add_row(bste_pkg::OP_SEARCH, KEY_MIN, KEY_MAX, 1'b1,
                make_res(bste_pkg::ST_NOT_FOUND, '0, 0, 0));
        add_row(bste_pkg::OP_INSERT, '0, KEY_MAX, 1'b1,
                make_res(bste_pkg::ST_INSERTED, '0, 0, 0));
        add_row(bste_pkg::OP_SEARCH, '0, '0, 1'b1,
                make_res(bste_pkg::ST_FOUND, KEY_MAX, 0, 1));
        add_row(bste_pkg::OP_INSERT, KEY_MAX, KEY_MIN, 1'b1,
                make_res(bste_pkg::ST_INSERTED, '0, 1, 1));
        add_row(bste_pkg::OP_INSERT, KEY_MIN, -32'sd1, 1'b1,
                make_res(bste_pkg::ST_INSERTED, '0, 2, 1));
        add_row(bste_pkg::OP_SEARCH, KEY_MAX, '0, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, KEY_MIN, -32'sd1, 1'b0, '0);
        // duplicate keys: the earliest node on the path wins
        add_row(bste_pkg::OP_INSERT, '0, 32'sd7, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, '0, '0, 1'b0, '0);
        add_row(bste_pkg::OP_INSERT, '0, 32'sd8, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, 32'sd1, '0, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, -32'sd1, '0, 1'b0, '0);
        add_row(bste_pkg::OP_INSERT, -32'sd1, '0, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, -32'sd1, '0, 1'b0, '0);
        add_row(bste_pkg::OP_INSERT, 32'sh7FFF_FFFE, 32'sh5555_5555, 1'b0, '0);
        add_row(bste_pkg::OP_INSERT, 32'sh8000_0001, 32'shAAAA_AAAA, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, 32'sh7FFF_FFFE, '0, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, 32'sh8000_0001, '0, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, KEY_MAX, 32'sh1234_5678, 1'b0, '0);
        add_row(bste_pkg::OP_SEARCH, 32'sh1234_5678, '0, 1'b0, '0);

        idle_pct  = 0;
        stall_pct = 0;
        foreach (directed_rows[r])
        begin
            want = predict_tree_op(directed_rows[r].op, directed_rows[r].key,
                                   directed_rows[r].pay);
            if (directed_rows[r].typed)
                want = directed_rows[r].want;
            send_request(directed_rows[r].op, directed_rows[r].key,
                         directed_rows[r].pay, want);
        end

        // random part: mixed traffic, then forced inserts fill the pool,
        // then a tail of refused inserts and searches on the full tree
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % SEG_LEN == 0)
            begin
                drain_results();
                case ((i / SEG_LEN) % 4)
                    0:
                    begin
                        idle_pct  = 0;
                        stall_pct = 0;
                    end
                    1:
                    begin
                        idle_pct  = 59;
                        stall_pct = 0;
                    end
                    2:
                    begin
                        idle_pct  = 0;
                        stall_pct = 59;
                    end
                    default:
                    begin
                        idle_pct  = 38;
                        stall_pct = 38;
                    end
                endcase
            end
            slots_left = POOL - tree_nodes;
            items_left = N_RANDOM - i;
            if (slots_left > 0 && slots_left + FULL_MARGIN >= items_left)
                op = bste_pkg::OP_INSERT;
            else
                op = ($urandom_range(99) < 80) ? bste_pkg::OP_INSERT
                                               : bste_pkg::OP_SEARCH;
            k    = pick_key(op == bste_pkg::OP_SEARCH);
            p    = $urandom;
            want = predict_tree_op(op, k, p);
            send_request(op, k, p, want);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);

        $display("Covered %0d inserts stored, %0d refused on a full pool,",
                 cnt_inserted, cnt_full);
        $display("%0d search hits and %0d misses; idling none, sender 59%%, %s",
                 cnt_found, cnt_missed, "receiver 59%, both 38%, drained between");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
